@@ sv/disc_brush_span_generator_macros.svh @@
// ----------------------------------------------------------------------------
// disc brush span generator assertion macros
// shared property shorthands, sampled on clk with arst_n as disable
// ----------------------------------------------------------------------------
`ifndef DISC_BRUSH_SPAN_GENERATOR_MACROS_SVH
`define DISC_BRUSH_SPAN_GENERATOR_MACROS_SVH

// same-cycle implication
`define DBSG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DBSG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/dbsg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsg_pkg
// types, constants and microcode rom of the disc brush span generator
// ----------------------------------------------------------------------------
package dbsg_pkg;

	localparam int XY_W    = 11;
	localparam int RIGHT_W = 12;
	localparam int COLOR_W = 16;
	localparam int DIM_W   = 12;
	localparam int RAD_W   = 5;
	localparam int SW      = 14;   // signed span arithmetic width

	localparam logic [DIM_W-1:0] SCREEN_LIMIT = 12'd2048;
	localparam logic [9:0]       IMAX_MUL     = 10'd724;
	localparam int               IMAX_SHIFT   = 10;

	// register map
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_SCREEN_WIDTH  = 2'd0;
	localparam reg_idx_t REG_SCREEN_HEIGHT = 2'd1;
	localparam reg_idx_t REG_BRUSH_RADIUS  = 2'd2;
	localparam reg_idx_t REG_PEN_COLOR     = 2'd3;

	localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH  = 12'd480;
	localparam logic [DIM_W-1:0]   RST_SCREEN_HEIGHT = 12'd854;
	localparam logic [RAD_W-1:0]   RST_BRUSH_RADIUS  = 5'd3;
	localparam logic [COLOR_W-1:0] RST_PEN_COLOR     = 16'hFFFF;

	// microprogram addresses
	typedef logic [3:0] upc_t;
	localparam upc_t UPC_WAIT   = 4'd0;
	localparam upc_t UPC_SETUP  = 4'd1;
	localparam upc_t UPC_CENTER = 4'd2;
	localparam upc_t UPC_TEST   = 4'd3;
	localparam upc_t UPC_CAP_HI = 4'd4;
	localparam upc_t UPC_CAP_LO = 4'd5;
	localparam upc_t UPC_ROW_HI = 4'd6;
	localparam upc_t UPC_ROW_LO = 4'd7;
	localparam upc_t UPC_POINT  = 4'd8;
	localparam upc_t UPC_OFF    = 4'd9;

	typedef enum logic [2:0] {
		SEL_POINT  = 3'd0,
		SEL_OFF    = 3'd1,
		SEL_CENTER = 3'd2,
		SEL_CAP_HI = 3'd3,
		SEL_CAP_LO = 3'd4,
		SEL_ROW_HI = 3'd5,
		SEL_ROW_LO = 3'd6
	} span_sel_t;

	typedef enum logic [1:0] {
		LAST_NO    = 2'd0,
		LAST_YES   = 2'd1,
		LAST_IMAX0 = 2'd2,
		LAST_IEND  = 2'd3
	} last_sel_t;

	typedef enum logic [2:0] {
		BR_NEXT     = 3'd0,
		BR_JUMP     = 3'd1,
		BR_WAIT_IN  = 3'd2,
		BR_DISPATCH = 3'd3,
		BR_IMAX0    = 3'd4,
		BR_NOCAP    = 3'd5,
		BR_LOOP     = 3'd6
	} branch_t;

	typedef enum logic [1:0] {
		XR_HOLD     = 2'd0,
		XR_DEC      = 2'd1,
		XR_DEC_TEST = 2'd2
	} xr_op_t;

	typedef struct packed {
		logic      emit;
		span_sel_t sel;
		last_sel_t last;
		branch_t   br;
		upc_t      target;
		logic      init;
		xr_op_t    xr_op;
		logic      adv_i;
	} ucode_t;

	typedef struct packed {
		logic r_zero;
		logic off_screen;
		logic imax_zero;
		logic i_end;
		logic cap_due;
		logic xr_shrink;
	} dp_status_t;

	function automatic ucode_t ucode_rom(input upc_t a);
		ucode_t w;
		case (a)
			UPC_WAIT:   w = '{1'b0, SEL_OFF, LAST_NO, BR_WAIT_IN, UPC_WAIT, 1'b0, XR_HOLD, 1'b0};
			UPC_SETUP:  w = '{1'b0, SEL_OFF, LAST_NO, BR_DISPATCH, UPC_POINT, 1'b1, XR_HOLD,
				1'b0};
			UPC_CENTER: w = '{1'b1, SEL_CENTER, LAST_IMAX0, BR_IMAX0, UPC_WAIT, 1'b0, XR_HOLD,
				1'b0};
			UPC_TEST:   w = '{1'b0, SEL_OFF, LAST_NO, BR_NOCAP, UPC_ROW_HI, 1'b0, XR_DEC_TEST,
				1'b0};
			UPC_CAP_HI: w = '{1'b1, SEL_CAP_HI, LAST_NO, BR_NEXT, UPC_WAIT, 1'b0, XR_HOLD, 1'b0};
			UPC_CAP_LO: w = '{1'b1, SEL_CAP_LO, LAST_NO, BR_NEXT, UPC_WAIT, 1'b0, XR_DEC, 1'b0};
			UPC_ROW_HI: w = '{1'b1, SEL_ROW_HI, LAST_NO, BR_NEXT, UPC_WAIT, 1'b0, XR_HOLD, 1'b0};
			UPC_ROW_LO: w = '{1'b1, SEL_ROW_LO, LAST_IEND, BR_LOOP, UPC_TEST, 1'b0, XR_HOLD,
				1'b1};
			UPC_POINT:  w = '{1'b1, SEL_POINT, LAST_YES, BR_JUMP, UPC_WAIT, 1'b0, XR_HOLD, 1'b0};
			UPC_OFF:    w = '{1'b1, SEL_OFF, LAST_YES, BR_JUMP, UPC_WAIT, 1'b0, XR_HOLD, 1'b0};
			default:    w = '{1'b0, SEL_OFF, LAST_NO, BR_JUMP, UPC_WAIT, 1'b0, XR_HOLD, 1'b0};
		endcase
		return w;
	endfunction

endpackage

@@ sv/dbsg_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsg_seq
// microprogram counter, control rom lookup and branch resolution
// ----------------------------------------------------------------------------
module dbsg_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_free,
	input  dbsg_pkg::dp_status_t st,
	output dbsg_pkg::upc_t      upc,
	output dbsg_pkg::ucode_t    uc,
	output logic                step_en,
	output logic                in_ready
);

	dbsg_pkg::upc_t upc_q;
	dbsg_pkg::upc_t upc_nxt;
	dbsg_pkg::upc_t upc_inc;

	assign uc       = dbsg_pkg::ucode_rom(upc_q);
	assign upc      = upc_q;
	assign step_en  = !uc.emit || out_free;
	assign in_ready = (uc.br == dbsg_pkg::BR_WAIT_IN);
	assign upc_inc  = dbsg_pkg::upc_t'(upc_q + 4'd1);

	always_comb begin
		case (uc.br)
			dbsg_pkg::BR_NEXT:     upc_nxt = upc_inc;
			dbsg_pkg::BR_JUMP:     upc_nxt = uc.target;
			dbsg_pkg::BR_WAIT_IN:  upc_nxt = in_valid ? upc_inc : upc_q;
			dbsg_pkg::BR_DISPATCH: begin
				// point brush, off-screen marker, or full disc
				if (st.r_zero)
					upc_nxt = uc.target;
				else if (st.off_screen)
					upc_nxt = dbsg_pkg::upc_t'(uc.target + 4'd1);
				else
					upc_nxt = upc_inc;
			end
			dbsg_pkg::BR_IMAX0:    upc_nxt = st.imax_zero ? uc.target : upc_inc;
			dbsg_pkg::BR_NOCAP:    upc_nxt = st.cap_due ? upc_inc : uc.target;
			dbsg_pkg::BR_LOOP:     upc_nxt = st.i_end ? dbsg_pkg::UPC_WAIT : uc.target;
			default:               upc_nxt = dbsg_pkg::UPC_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= dbsg_pkg::UPC_WAIT;
		end else if (step_en) begin
			upc_q <= upc_nxt;
		end
	end

endmodule

@@ sv/dbsg_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbsg_dp
// disc walk registers, span clipping and the output register
// ----------------------------------------------------------------------------
module dbsg_dp #(
	parameter int MAX_RADIUS = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dbsg_pkg::ucode_t                 uc,
	input  logic                             step_en,
	input  logic                             in_fire,
	input  logic [dbsg_pkg::XY_W-1:0]        in_x,
	input  logic [dbsg_pkg::XY_W-1:0]        in_y,
	input  logic [dbsg_pkg::RAD_W-1:0]       radius,
	input  logic [dbsg_pkg::DIM_W-1:0]       width,
	input  logic [dbsg_pkg::DIM_W-1:0]       height,
	input  logic [dbsg_pkg::COLOR_W-1:0]     color,
	input  logic                             out_ready,
	output dbsg_pkg::dp_status_t             st,
	output logic                             out_free,
	output logic                             out_valid,
	output logic                             span_visible,
	output logic [dbsg_pkg::XY_W-1:0]        span_row,
	output logic [dbsg_pkg::XY_W-1:0]        span_left,
	output logic [dbsg_pkg::RIGHT_W-1:0]     span_right,
	output logic [dbsg_pkg::COLOR_W-1:0]     span_color,
	output logic                             span_last
);

	localparam int RB  = $clog2(MAX_RADIUS + 1);
	localparam int SQB = 2 * RB + 2;
	localparam int MW  = RB + 10;
	localparam int SW  = dbsg_pkg::SW;

	localparam logic signed [SW-1:0] S_ZERO = '0;
	localparam logic signed [SW-1:0] S_ONE  = SW'(1);

	logic [dbsg_pkg::XY_W-1:0] x_q, y_q;
	logic [RB-1:0]             r_q, imax_q, i_q, xr_q;
	logic [SQB-1:0]            sqmax_q, isq_q;

	logic [RB-1:0]  r_sat;
	logic [MW-1:0]  r724;
	logic [SQB-1:0] r_sq, xr_sq, test_sum;
	logic           rad_hit, xr_gt_imax;
	logic           fire;

	logic [dbsg_pkg::DIM_W-1:0] w_c, h_c;
	logic signed [SW-1:0] sx, sy, sr, sxr, si, sw_s, sh_s;
	logic signed [SW-1:0] x0, row, len, b, a_c, b_c;
	logic                 show, vis, last_bit;

	// radius saturation
	assign r_sat = (radius > dbsg_pkg::RAD_W'(MAX_RADIUS)) ? RB'(MAX_RADIUS) : RB'(radius);

	assign r724 = MW'(r_q) * MW'(dbsg_pkg::IMAX_MUL);
	assign r_sq = SQB'(r_q) * SQB'(r_q);

	// circle test for the current row
	assign xr_sq      = SQB'(xr_q) * SQB'(xr_q);
	assign test_sum   = isq_q + xr_sq;
	assign rad_hit    = test_sum > sqmax_q;
	assign xr_gt_imax = xr_q > imax_q;

	assign w_c  = (width > dbsg_pkg::SCREEN_LIMIT) ? dbsg_pkg::SCREEN_LIMIT : width;
	assign h_c  = (height > dbsg_pkg::SCREEN_LIMIT) ? dbsg_pkg::SCREEN_LIMIT : height;
	assign sx   = $signed(SW'(x_q));
	assign sy   = $signed(SW'(y_q));
	assign sr   = $signed(SW'(r_q));
	assign sxr  = $signed(SW'(xr_q));
	assign si   = $signed(SW'(i_q));
	assign sw_s = $signed(SW'(w_c));
	assign sh_s = $signed(SW'(h_c));

	assign st.r_zero     = (r_q == '0);
	assign st.off_screen = ((sx - sr) >= sw_s) || ((sy - sr) >= sh_s);
	assign st.imax_zero  = (imax_q == '0);
	assign st.i_end      = (i_q == imax_q);
	assign st.cap_due    = rad_hit && xr_gt_imax;
	assign st.xr_shrink  = rad_hit && !xr_gt_imax;

	always_comb begin
		show = 1'b1;
		x0   = sx;
		row  = sy;
		len  = S_ONE;
		case (uc.sel)
			dbsg_pkg::SEL_POINT: begin
				x0 = sx;
			end
			dbsg_pkg::SEL_CENTER: begin
				x0  = sx - sr;
				len = (sr <<< 1) + S_ONE;
			end
			dbsg_pkg::SEL_CAP_HI: begin
				x0  = sx - si + S_ONE;
				row = sy + sxr;
				len = (si <<< 1) - S_ONE;
			end
			dbsg_pkg::SEL_CAP_LO: begin
				x0  = sx - si + S_ONE;
				row = sy - sxr;
				len = (si <<< 1) - S_ONE;
			end
			dbsg_pkg::SEL_ROW_HI: begin
				x0  = sx - sxr;
				row = sy + si;
				len = (sxr <<< 1) + S_ONE;
			end
			dbsg_pkg::SEL_ROW_LO: begin
				x0  = sx - sxr;
				row = sy - si;
				len = (sxr <<< 1) + S_ONE;
			end
			default: begin
				show = 1'b0;
			end
		endcase
	end

	// clip to the screen
	assign b   = x0 + len;
	assign a_c = (x0 < S_ZERO) ? S_ZERO : x0;
	assign b_c = (b > sw_s) ? sw_s : b;
	assign vis = show && (row >= S_ZERO) && (row < sh_s) && (a_c < b_c);

	always_comb begin
		case (uc.last)
			dbsg_pkg::LAST_NO:    last_bit = 1'b0;
			dbsg_pkg::LAST_YES:   last_bit = 1'b1;
			dbsg_pkg::LAST_IMAX0: last_bit = st.imax_zero;
			dbsg_pkg::LAST_IEND:  last_bit = st.i_end;
			default:              last_bit = 1'b0;
		endcase
	end

	assign fire     = uc.emit && step_en;
	assign out_free = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q <= in_x;
			y_q <= in_y;
			r_q <= r_sat;
		end
		if (step_en && uc.init) begin
			imax_q  <= r724[MW-1:dbsg_pkg::IMAX_SHIFT];
			sqmax_q <= r_sq + SQB'(r_q >> 1);
			xr_q    <= r_q;
			isq_q   <= SQB'(1);
			i_q     <= RB'(1);
		end else begin
			if (step_en && ((uc.xr_op == dbsg_pkg::XR_DEC) ||
					((uc.xr_op == dbsg_pkg::XR_DEC_TEST) && st.xr_shrink))) begin
				xr_q <= xr_q - RB'(1);
			end
			if (step_en && uc.adv_i) begin
				isq_q <= isq_q + SQB'({i_q, 1'b1});
				i_q   <= i_q + RB'(1);
			end
		end
		if (fire) begin
			span_visible <= vis;
			span_row     <= vis ? row[dbsg_pkg::XY_W-1:0] : '0;
			span_left    <= vis ? a_c[dbsg_pkg::XY_W-1:0] : '0;
			span_right   <= vis ? b_c[dbsg_pkg::RIGHT_W-1:0] : '0;
			span_color   <= vis ? color : '0;
			span_last    <= last_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

endmodule

@@ sv/disc_brush_span_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disc_brush_span_generator
// after a center is taken, setup dispatches to a point, off-screen or center step that registers the first span
// a radius 0 or off-screen disc yields a single span; otherwise the span steps each emit one span,
//   with one test step per row pair
// the microprogram walks one center at a time; output backpressure freezes the step counter
// reset: arst_n clears the step counter and output valid, config returns to its reset values
// ----------------------------------------------------------------------------
`include "disc_brush_span_generator_macros.svh"

module disc_brush_span_generator #(
	parameter int MAX_RADIUS = 20,
	parameter int COORD_BITS = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream: one brush center per transaction
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // center_x [10:0], center_y [21:11]
	// output stream: one span per transaction
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // span_row [10:0], span_left [21:11],
	                               // span_right [33:22], span_color [49:34]
	output logic [0:0]  m_tuser,   // span_visible [0]
	output logic        m_tlast,   // last_span
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// coordinate mask, limited to the port width
	localparam int CB = (COORD_BITS < dbsg_pkg::XY_W) ? COORD_BITS : dbsg_pkg::XY_W;
	localparam logic [dbsg_pkg::XY_W-1:0] CMASK = dbsg_pkg::XY_W'((32'd1 << CB) - 32'd1);

	// config registers
	logic [dbsg_pkg::DIM_W-1:0]   screen_width_q;
	logic [dbsg_pkg::DIM_W-1:0]   screen_height_q;
	logic [dbsg_pkg::RAD_W-1:0]   brush_radius_q;
	logic [dbsg_pkg::COLOR_W-1:0] pen_color_q;
	logic                         cfg_wr;
	dbsg_pkg::reg_idx_t           reg_idx;

	// sequencer <-> datapath
	dbsg_pkg::ucode_t     uc;
	dbsg_pkg::upc_t       upc;
	dbsg_pkg::dp_status_t st;
	logic                 step_en;
	logic                 in_fire;
	logic                 out_free;

	logic [dbsg_pkg::XY_W-1:0]    center_x, center_y;
	logic                         span_visible;
	logic [dbsg_pkg::XY_W-1:0]    span_row, span_left;
	logic [dbsg_pkg::RIGHT_W-1:0] span_right;
	logic [dbsg_pkg::COLOR_W-1:0] span_color;

	// ---------------- register port ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= dbsg_pkg::RST_SCREEN_WIDTH;
			screen_height_q <= dbsg_pkg::RST_SCREEN_HEIGHT;
			brush_radius_q  <= dbsg_pkg::RST_BRUSH_RADIUS;
			pen_color_q     <= dbsg_pkg::RST_PEN_COLOR;
		end else if (cfg_wr) begin
			case (reg_idx)
				dbsg_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[dbsg_pkg::DIM_W-1:0];
				dbsg_pkg::REG_SCREEN_HEIGHT: screen_height_q <= pwdata[dbsg_pkg::DIM_W-1:0];
				dbsg_pkg::REG_BRUSH_RADIUS:  brush_radius_q  <= pwdata[dbsg_pkg::RAD_W-1:0];
				dbsg_pkg::REG_PEN_COLOR:     pen_color_q     <= pwdata[dbsg_pkg::COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// read back, zero-extended to the bus
	always_comb begin
		case (reg_idx)
			dbsg_pkg::REG_SCREEN_WIDTH:  prdata = 32'(screen_width_q);
			dbsg_pkg::REG_SCREEN_HEIGHT: prdata = 32'(screen_height_q);
			dbsg_pkg::REG_BRUSH_RADIUS:  prdata = 32'(brush_radius_q);
			dbsg_pkg::REG_PEN_COLOR:     prdata = 32'(pen_color_q);
			default:                     prdata = '0;
		endcase
	end

	// ---------------- input unpack ----------------
	assign center_x = s_tdata[10:0] & CMASK;
	assign center_y = s_tdata[21:11] & CMASK;
	assign in_fire  = s_tvalid && s_tready;

	// ---------------- microcoded control ----------------
	// the rom walks: wait, setup/dispatch, then a point or off-screen span, or the center row
	// and per row pair an optional cap pair followed by the two rows of the current radius
	dbsg_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.st       (st),
		.upc      (upc),
		.uc       (uc),
		.step_en  (step_en),
		.in_ready (s_tready)
	);

	// ---------------- datapath ----------------
	dbsg_dp #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.uc           (uc),
		.step_en      (step_en),
		.in_fire      (in_fire),
		.in_x         (center_x),
		.in_y         (center_y),
		.radius       (brush_radius_q),
		.width        (screen_width_q),
		.height       (screen_height_q),
		.color        (pen_color_q),
		.out_ready    (m_tready),
		.st           (st),
		.out_free     (out_free),
		.out_valid    (m_tvalid),
		.span_visible (span_visible),
		.span_row     (span_row),
		.span_left    (span_left),
		.span_right   (span_right),
		.span_color   (span_color),
		.span_last    (m_tlast)
	);

	// ---------------- output pack ----------------
	assign m_tdata    = {6'b0, span_color, span_right, span_left, span_row};
	assign m_tuser[0] = span_visible;

	// ---------------- checks ----------------
	// an accepted center always enters the dispatch step next
	`DBSG_ASSERT_NXT(a_accept_setup, in_fire, upc == dbsg_pkg::UPC_SETUP, "no dispatch")
	// a blocked span step must not advance the program
	`DBSG_ASSERT_NXT(a_stall_hold, uc.emit && !out_free, $stable(upc), "moved in stall")
	// an invisible span carries all-zero payload
	`DBSG_ASSERT_IMP(a_invis_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "invisible data")

endmodule
